FILE: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared constants for the sorted priority queue
// Field widths of the request and response ports, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int VALUE_W     = 32;
   localparam int PRIO_PORT_W = 16;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/spq_entry_ram.sv
// ----------------------------------------------------------------------------
// spq_entry_ram: entry storage of the sorted priority queue
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_entry_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 48,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept in priority order
// Lowest priority number is served first, equal priorities in arrival order.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  req_      in         req_valid/stall     operation, value, priority_req
//  rsp_      out        rsp_valid/stall     removed_value, removed_valid,
//                                           status, entry_count
//
//  Remove on empty, insert on full and insert into an empty queue answer
//  straight from idle; a remove makes one memory read. An insert walks back
//  from the tail through the single read port, one entry per cycle, until
//  it meets an entry with an equal or smaller priority number or the head.
//  Reset clears state, count and head pointer; the entry memory is not swept.
//  req_stall is high while a request is in flight or a response is stalled.
//
// Entries live in a circular buffer: logical slot L sits at (head + L) mod
// CAPACITY, so a remove only advances the head. An insert shifts the tail
// entries up by one, read-compare-write per cycle, then drops the new entry
// into the freed slot. Reads and writes of a walk never target the same
// slot in the same cycle, so no forwarding is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
   parameter int CAPACITY       = 16,
   parameter int PRIORITY_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_operation,
   input  wire logic signed [spq_pkg::VALUE_W-1:0] req_value,
   input  wire logic [spq_pkg::PRIO_PORT_W-1:0]   req_priority_req,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [spq_pkg::VALUE_W-1:0]     rsp_removed_value,
   output logic                                   rsp_removed_valid,
   output logic [spq_pkg::STATUS_W-1:0]           rsp_status,
   output logic [spq_pkg::COUNT_OUT_W-1:0]        rsp_entry_count
);

   import spq_pkg::*;

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int ENTRY_W = VALUE_W + PRIORITY_WIDTH;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RMV   = 2'd1;  // head entry arriving from memory
   localparam logic [1:0] S_WALK  = 2'd2;  // shifting tail entries up
   localparam logic [1:0] S_PLACE = 2'd3;  // new entry goes to logical slot 0

   // logical slot to memory address
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [IDX_W-1:0] slot);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, slot};
      if (sum >= (IDX_W+1)'(CAPACITY)) begin
         sum = sum - (IDX_W+1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   // control state
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // held request payload
   logic [VALUE_W-1:0]        val_ff, val_in;
   logic [PRIORITY_WIDTH-1:0] pr_ff, pr_in;

   // response register
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                   rsp_rvalid_ff, rsp_rvalid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   // memory port
   logic               wr_en, rd_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   logic                           req_fire;
   logic                           rsp_load;
   logic [PRIORITY_WIDTH+PRIO_PORT_W-1:0] pr_ext;
   logic [CNT_W+COUNT_OUT_W-1:0]   count_ext;
   logic [PRIORITY_WIDTH-1:0]      rd_prio;
   logic [VALUE_W-1:0]             rd_value;
   logic                           is_full, is_empty;

   spq_entry_ram #(
      .DEPTH  (CAPACITY),
      .WIDTH  (ENTRY_W),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;

   // priority bits above PRIORITY_WIDTH are dropped; narrow port zero-extends
   assign pr_ext   = (PRIORITY_WIDTH+PRIO_PORT_W)'(req_priority_req);
   assign rd_prio  = rd_data[PRIORITY_WIDTH-1:0];
   assign rd_value = rd_data[ENTRY_W-1:PRIORITY_WIDTH];
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      slot_in       = slot_ff;
      val_in        = val_ff;
      pr_in         = pr_ff;
      rsp_load      = 1'b0;
      rsp_value_in  = '0;
      rsp_rvalid_in = 1'b0;
      rsp_status_in = ST_OK;
      wr_en         = 1'b0;
      wr_addr       = phys(head_ff, slot_ff + IDX_W'(1));
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               val_in = req_value;
               pr_in  = pr_ext[PRIORITY_WIDTH-1:0];
               if (req_operation == OP_REMOVE) begin
                  if (is_empty) begin
                     rsp_load      = 1'b1;
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     head_in  = phys(head_ff, IDX_W'(1));
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_RMV;
                  end
               end else begin
                  if (is_full) begin
                     rsp_load      = 1'b1;
                     rsp_status_in = ST_FULL;
                  end else if (is_empty) begin
                     // first entry: straight to the head slot
                     wr_en    = 1'b1;
                     wr_addr  = head_ff;
                     wr_data  = {req_value, pr_ext[PRIORITY_WIDTH-1:0]};
                     count_in = count_ff + CNT_W'(1);
                     rsp_load = 1'b1;
                  end else begin
                     // start from the tail
                     slot_in  = IDX_W'(count_ff - CNT_W'(1));
                     rd_en    = 1'b1;
                     rd_addr  = phys(head_ff, IDX_W'(count_ff - CNT_W'(1)));
                     count_in = count_ff + CNT_W'(1);
                     state_in = S_WALK;
                  end
               end
            end
         end
         S_RMV: begin
            rsp_load      = 1'b1;
            rsp_value_in  = rd_value;
            rsp_rvalid_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_WALK: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, slot_ff + IDX_W'(1));
            if (rd_prio > pr_ff) begin
               // larger number: move it up one slot
               wr_data = rd_data;
               if (slot_ff == '0) begin
                  state_in = S_PLACE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = phys(head_ff, slot_ff - IDX_W'(1));
                  slot_in  = slot_ff - IDX_W'(1);
               end
            end else begin
               // equal or smaller stays ahead of the new entry
               wr_data  = {val_ff, pr_ff};
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = head_ff;
            wr_data  = {val_ff, pr_ff};
            rsp_load = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      count_ext    = (CNT_W+COUNT_OUT_W)'(count_in);
      rsp_count_in = count_ext[COUNT_OUT_W-1:0];

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      pr_ff  <= pr_in;
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_rvalid_ff <= rsp_rvalid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_value_ff;
   assign rsp_removed_valid = rsp_rvalid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_count   = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response register occupied while a request is in flight");

   a_walk_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> ((CNT_W+1)'(slot_ff) + (CNT_W+1)'(1) <
                                (CNT_W+1)'(count_ff)))
      else $error("insert walk slot outside held entries");

   a_rmv_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMV) |=> (state_ff == S_IDLE) && rsp_valid_ff && rsp_removed_valid)
      else $error("remove did not deliver its response");

   a_rvalid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rvalid_ff) |-> (rsp_status_ff == ST_OK))
      else $error("removed value flagged with error status");
`endif

endmodule

`default_nettype wire
